// ===== hdl/part_pkg.sv =====
package part_pkg;

  localparam int unsigned SeqBufDepthDefault = 256;
  localparam int unsigned AckMapBits         = 32;
  localparam int unsigned AckCntW            = $clog2(AckMapBits + 1);
  localparam logic [12:0] AlphaQ16           = 13'd6554;
  localparam logic [7:0]  LossHorizonReset   = 8'd32;
  localparam logic [37:0] RoundHalf          = 38'd32768;

  typedef enum logic [1:0] {
    CmdSend = 2'd0,
    CmdRecv = 2'd1,
    CmdTick = 2'd2,
    CmdNop  = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    StClear,
    StIdle,
    StSndMap,
    StRcvRd,
    StRcvChk,
    StAckRd,
    StAckChk,
    StBlDiff,
    StBlMlo,
    StBlMhi,
    StBlApply,
    StTckInit,
    StTckRd,
    StTckChk,
    StOut
  } state_e;

  typedef enum logic [1:0] {
    PhJitTarget,
    PhJit,
    PhAvg
  } phase_e;

  // True when a is ahead of b in the wrapping 16-bit sequence space.
  function automatic logic seq_newer(logic [15:0] a, logic [15:0] b);
    logic [15:0] ab;
    logic [15:0] ba;
    ab = a - b;
    ba = b - a;
    return ((a > b) && (ab <= 16'd32768)) || ((a < b) && (ba > 16'd32768));
  endfunction

endpackage

// ===== hdl/packet_ack_rtt_tracker_unit.sv =====
// Packet acknowledgement and round-trip tracker for one link endpoint.
// Requests arrive on the in_valid_i/in_ready_o channel; each request gives
// exactly one result on the out_valid_o/out_ready_i channel. A send request
// takes the next sequence number and returns the ack header, a receive
// request records a sequence and applies the partner's ack map to the sent
// packets, and a tick request counts packets fallen behind the loss horizon.
// One request is handled at a time: in_ready_o is high only while idle.
// A send keeps the block busy from acceptance until the receive buffer
// has been read for every bit of the ack map. A receive first checks the
// receive buffer for a duplicate, then works through the candidate acks;
// each candidate ack costs one sent-buffer read, and each packet newly
// acknowledged after the first round-trip sample runs a round-trip update
// through the shared multiplier in halves. A tick reads the sent buffer
// for each sequence scanned. After reset the block clears both sequence
// buffers before it accepts its first request; the loss horizon register
// can be written throughout. A result is held in the output register until
// the receiver takes it, and no new request is accepted meanwhile.
// SEQ_BUF_DEPTH must be a power of two.
module packet_ack_rtt_tracker_unit #(
  parameter int unsigned SEQ_BUF_DEPTH = part_pkg::SeqBufDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  cmd_i,
  input  logic [31:0] now_us_i,
  input  logic [15:0] rx_sequence_i,
  input  logic [15:0] rx_ack_i,
  input  logic [31:0] rx_ack_bits_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] tx_sequence_o,
  output logic [15:0] tx_ack_o,
  output logic [31:0] tx_ack_bits_o,
  output logic        rx_accepted_o,
  output logic [31:0] rtt_avg_us_o,
  output logic [31:0] rtt_jitter_us_o,
  output logic [31:0] rtt_min_us_o,
  output logic [31:0] acked_total_o,
  output logic [31:0] lost_total_o
);

  localparam int unsigned SlotW = $clog2(SEQ_BUF_DEPTH);
  localparam int unsigned CntW  = part_pkg::AckCntW;
  localparam logic [CntW-1:0] CntLast = CntW'(part_pkg::AckMapBits);
  localparam logic [SlotW-1:0] ClrLast = SlotW'(SEQ_BUF_DEPTH - 1);

  // Sent buffer word: valid, acked, tag, send time. Receive word: valid, tag.
  logic [49:0] sent_mem [SEQ_BUF_DEPTH];
  logic [16:0] recv_mem [SEQ_BUF_DEPTH];
  logic [49:0] sent_rd_q;
  logic [16:0] recv_rd_q;
  logic             sent_we, recv_we;
  logic [SlotW-1:0] sent_wa, sent_ra, recv_wa, recv_ra;
  logic [49:0]      sent_wd;
  logic [16:0]      recv_wd;

  part_pkg::state_e state_q, state_d;
  part_pkg::phase_e phase_q, phase_d;
  part_pkg::cmd_e   cmd_in;

  logic [1:0]       cmd_q, cmd_d;
  logic [31:0]      now_q, now_d;
  logic [15:0]      rseq_q, rseq_d, rack_q, rack_d;
  logic [31:0]      rbits_q, rbits_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [SlotW-1:0] clr_q, clr_d;
  logic [15:0]      txs_q, txs_d, txa_q, txa_d;
  logic [31:0]      txb_q, txb_d;
  logic             acc_q, acc_d;
  logic [15:0]      next_seq_q, next_seq_d, newest_q, newest_d;
  logic             have_recv_q, have_recv_d;
  logic [47:0]      avg_q, avg_d, jit_q, jit_d;
  logic [31:0]      least_q, least_d;
  logic             started_q, started_d;
  logic [15:0]      cursor_q, cursor_d;
  logic             have_cur_q, have_cur_d;
  logic [31:0]      acked_q, acked_d, lost_q, lost_d;
  logic [7:0]       loss_q;
  logic [47:0]      cur_q, cur_d, tgt_q, tgt_d, d_q, d_d, step_q, step_d;
  logic             dir_q, dir_d;
  logic [37:0]      prod_q, prod_d;
  logic [31:0]      sample_q, sample_d;

  logic        accept;
  logic [15:0] map_seq, map_chk_seq, ack_seq, horizon;
  logic        recv_hit, map_hit, sent_hit, ack_want, ack_last, tick_more, lost_hit;
  logic        diff_ge;
  logic [47:0] diff_abs, blend_res;
  logic [23:0] mul_a;
  logic [36:0] mul_p;
  logic [60:0] hi_sum;
  logic [4:0]  bit_idx;

  assign cmd_in      = part_pkg::cmd_e'(cmd_i);
  assign accept      = in_valid_i && in_ready_o;
  assign map_seq     = newest_q - 16'(cnt_q) - 16'd1;
  assign map_chk_seq = newest_q - 16'(cnt_q);
  assign bit_idx     = cnt_q[4:0] - 5'd1;
  assign ack_seq     = rack_q - 16'(cnt_q);
  assign horizon     = next_seq_q - 16'(loss_q);

  assign recv_hit  = recv_rd_q[16] && (recv_rd_q[15:0] == rseq_q);
  assign map_hit   = recv_rd_q[16] && (recv_rd_q[15:0] == map_chk_seq);
  assign sent_hit  = sent_rd_q[49] && !sent_rd_q[48] && (sent_rd_q[47:32] == ack_seq);
  assign lost_hit  = sent_rd_q[49] && !sent_rd_q[48] && (sent_rd_q[47:32] == cursor_q);
  assign ack_want  = (cnt_q == '0) || rbits_q[bit_idx];
  assign ack_last  = (cnt_q == CntLast);
  assign tick_more = part_pkg::seq_newer(horizon, cursor_q);

  // Shared absolute-difference unit and shared multiplier.
  assign diff_ge   = tgt_q >= cur_q;
  assign diff_abs  = diff_ge ? (tgt_q - cur_q) : (cur_q - tgt_q);
  assign mul_a     = (state_q == part_pkg::StBlMlo) ? d_q[23:0] : d_q[47:24];
  assign mul_p     = 37'(mul_a) * 37'(part_pkg::AlphaQ16);
  assign hi_sum    = {mul_p, 24'd0} + 61'(prod_q);
  assign blend_res = dir_q ? (cur_q + step_q) : (cur_q - step_q);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      part_pkg::StClear: begin
        if (clr_q == ClrLast) state_d = part_pkg::StIdle;
      end
      part_pkg::StIdle: begin
        if (accept) begin
          unique case (cmd_in)
            part_pkg::CmdSend: state_d = part_pkg::StSndMap;
            part_pkg::CmdRecv: state_d = part_pkg::StRcvRd;
            part_pkg::CmdTick: state_d = part_pkg::StTckInit;
            part_pkg::CmdNop:  state_d = part_pkg::StOut;
            default:           state_d = part_pkg::StOut;
          endcase
        end
      end
      part_pkg::StSndMap: begin
        if (ack_last) state_d = part_pkg::StOut;
      end
      part_pkg::StRcvRd:  state_d = part_pkg::StRcvChk;
      part_pkg::StRcvChk: state_d = recv_hit ? part_pkg::StOut : part_pkg::StAckRd;
      part_pkg::StAckRd: begin
        if (ack_want) state_d = part_pkg::StAckChk;
        else if (ack_last) state_d = part_pkg::StOut;
      end
      part_pkg::StAckChk: begin
        if (sent_hit && started_q) state_d = part_pkg::StBlDiff;
        else if (ack_last) state_d = part_pkg::StOut;
        else state_d = part_pkg::StAckRd;
      end
      part_pkg::StBlDiff: begin
        if (phase_q != part_pkg::PhJitTarget) state_d = part_pkg::StBlMlo;
      end
      part_pkg::StBlMlo: state_d = part_pkg::StBlMhi;
      part_pkg::StBlMhi: state_d = part_pkg::StBlApply;
      part_pkg::StBlApply: begin
        if (phase_q == part_pkg::PhJit) state_d = part_pkg::StBlDiff;
        else if (ack_last) state_d = part_pkg::StOut;
        else state_d = part_pkg::StAckRd;
      end
      part_pkg::StTckInit: state_d = part_pkg::StTckRd;
      part_pkg::StTckRd:   state_d = tick_more ? part_pkg::StTckChk : part_pkg::StOut;
      part_pkg::StTckChk:  state_d = part_pkg::StTckRd;
      part_pkg::StOut: begin
        if (out_ready_i) state_d = part_pkg::StIdle;
      end
      default: state_d = part_pkg::StIdle;
    endcase
  end

  // Handshake and buffer port controls.
  always_comb begin
    in_ready_o  = (state_q == part_pkg::StIdle);
    out_valid_o = (state_q == part_pkg::StOut);
    sent_we = 1'b0;
    sent_wa = next_seq_q[SlotW-1:0];
    sent_wd = {1'b1, 1'b0, next_seq_q, now_us_i};
    sent_ra = (state_q == part_pkg::StTckRd) ? cursor_q[SlotW-1:0] : ack_seq[SlotW-1:0];
    recv_we = 1'b0;
    recv_wa = rseq_q[SlotW-1:0];
    recv_wd = {1'b1, rseq_q};
    recv_ra = (state_q == part_pkg::StSndMap) ? map_seq[SlotW-1:0] : rseq_q[SlotW-1:0];
    unique case (state_q)
      part_pkg::StClear: begin
        sent_we = 1'b1;
        sent_wa = clr_q;
        sent_wd = '0;
        recv_we = 1'b1;
        recv_wa = clr_q;
        recv_wd = '0;
      end
      part_pkg::StIdle: begin
        sent_we = accept && (cmd_in == part_pkg::CmdSend);
      end
      part_pkg::StRcvChk: begin
        recv_we = !recv_hit;
      end
      part_pkg::StAckChk: begin
        sent_we = sent_hit;
        sent_wa = ack_seq[SlotW-1:0];
        sent_wd = {1'b1, 1'b1, sent_rd_q[47:0]};
      end
      default: begin
      end
    endcase
  end

  // Datapath next values.
  always_comb begin
    cmd_d = cmd_q; now_d = now_q; rseq_d = rseq_q; rack_d = rack_q; rbits_d = rbits_q;
    cnt_d = cnt_q; clr_d = clr_q; txs_d = txs_q; txa_d = txa_q; txb_d = txb_q;
    acc_d = acc_q; next_seq_d = next_seq_q; newest_d = newest_q;
    have_recv_d = have_recv_q; avg_d = avg_q; jit_d = jit_q; least_d = least_q;
    started_d = started_q; cursor_d = cursor_q; have_cur_d = have_cur_q;
    acked_d = acked_q; lost_d = lost_q; cur_d = cur_q; tgt_d = tgt_q; d_d = d_q;
    dir_d = dir_q; prod_d = prod_q; step_d = step_q; sample_d = sample_q;
    phase_d = phase_q;
    unique case (state_q)
      part_pkg::StClear: clr_d = clr_q + 1'b1;
      part_pkg::StIdle: begin
        if (accept) begin
          cmd_d = cmd_i; now_d = now_us_i; rseq_d = rx_sequence_i;
          rack_d = rx_ack_i; rbits_d = rx_ack_bits_i;
          cnt_d = '0; txs_d = '0; txa_d = '0; txb_d = '0; acc_d = 1'b0;
          if (cmd_in == part_pkg::CmdSend) begin
            txs_d = next_seq_q;
            txa_d = newest_q;
            next_seq_d = next_seq_q + 16'd1;
          end
        end
      end
      part_pkg::StSndMap: begin
        if (cnt_q != '0 && map_hit) txb_d[bit_idx] = 1'b1;
        cnt_d = cnt_q + 1'b1;
      end
      part_pkg::StRcvChk: begin
        if (!recv_hit) begin
          acc_d = 1'b1;
          have_recv_d = 1'b1;
          if (!have_recv_q || part_pkg::seq_newer(rseq_q, newest_q)) newest_d = rseq_q;
        end
      end
      part_pkg::StAckRd: begin
        if (!ack_want) cnt_d = cnt_q + 1'b1;
      end
      part_pkg::StAckChk: begin
        if (sent_hit) begin
          acked_d = acked_q + 32'd1;
          sample_d = now_q - sent_rd_q[31:0];
          if (!started_q) begin
            avg_d = {now_q - sent_rd_q[31:0], 16'd0};
            least_d = now_q - sent_rd_q[31:0];
            started_d = 1'b1;
            cnt_d = cnt_q + 1'b1;
          end else begin
            cur_d = avg_q;
            tgt_d = {now_q - sent_rd_q[31:0], 16'd0};
            phase_d = part_pkg::PhJitTarget;
          end
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      part_pkg::StBlDiff: begin
        if (phase_q == part_pkg::PhJitTarget) begin
          // The jitter target is the distance of the sample from the average.
          tgt_d = diff_abs;
          cur_d = jit_q;
          phase_d = part_pkg::PhJit;
        end else begin
          d_d = diff_abs;
          dir_d = diff_ge;
        end
      end
      part_pkg::StBlMlo: prod_d = {1'b0, mul_p} + part_pkg::RoundHalf;
      part_pkg::StBlMhi: step_d = 48'(hi_sum[60:16]);
      part_pkg::StBlApply: begin
        if (phase_q == part_pkg::PhJit) begin
          jit_d = blend_res;
          cur_d = avg_q;
          tgt_d = {sample_q, 16'd0};
          phase_d = part_pkg::PhAvg;
        end else begin
          avg_d = blend_res;
          if (sample_q < least_q) least_d = sample_q;
          cnt_d = cnt_q + 1'b1;
        end
      end
      part_pkg::StTckInit: begin
        if (!have_cur_q) begin
          cursor_d = horizon;
          have_cur_d = 1'b1;
        end
      end
      part_pkg::StTckChk: begin
        if (lost_hit) lost_d = lost_q + 32'd1;
        cursor_d = cursor_q + 16'd1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= part_pkg::StClear;
      phase_q <= part_pkg::PhJitTarget;
      clr_q <= '0;
      loss_q <= part_pkg::LossHorizonReset;
      next_seq_q <= '0;
      newest_q <= '0;
      have_recv_q <= 1'b0;
      avg_q <= '0;
      jit_q <= '0;
      least_q <= '0;
      started_q <= 1'b0;
      cursor_q <= '0;
      have_cur_q <= 1'b0;
      acked_q <= '0;
      lost_q <= '0;
      cnt_q <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      clr_q <= clr_d;
      if (cfg_we_i) loss_q <= cfg_wdata_i;
      next_seq_q <= next_seq_d;
      newest_q <= newest_d;
      have_recv_q <= have_recv_d;
      avg_q <= avg_d;
      jit_q <= jit_d;
      least_q <= least_d;
      started_q <= started_d;
      cursor_q <= cursor_d;
      have_cur_q <= have_cur_d;
      acked_q <= acked_d;
      lost_q <= lost_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d; now_q <= now_d; rseq_q <= rseq_d; rack_q <= rack_d;
    rbits_q <= rbits_d; txs_q <= txs_d; txa_q <= txa_d; txb_q <= txb_d;
    acc_q <= acc_d; cur_q <= cur_d; tgt_q <= tgt_d; d_q <= d_d; dir_q <= dir_d;
    prod_q <= prod_d; step_q <= step_d; sample_q <= sample_d;
  end

  always_ff @(posedge clk_i) begin
    if (sent_we) sent_mem[sent_wa] <= sent_wd;
    sent_rd_q <= sent_mem[sent_ra];
  end

  always_ff @(posedge clk_i) begin
    if (recv_we) recv_mem[recv_wa] <= recv_wd;
    recv_rd_q <= recv_mem[recv_ra];
  end

  assign tx_sequence_o   = txs_q;
  assign tx_ack_o        = txa_q;
  assign tx_ack_bits_o   = txb_q;
  assign rx_accepted_o   = acc_q & (cmd_q == part_pkg::CmdRecv);
  assign rtt_avg_us_o    = avg_q[47:16];
  assign rtt_jitter_us_o = jit_q[47:16];
  assign rtt_min_us_o    = least_q;
  assign acked_total_o   = acked_q;
  assign lost_total_o    = lost_q;

endmodule

// ===== tb/packet_ack_rtt_tracker_unit_test.sv =====
module packet_ack_rtt_tracker_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  // A request as offered on the input channel.
  typedef struct packed {
    part_pkg::cmd_e cmd;
    logic [31:0]    now;
    logic [15:0]    rseq;
    logic [15:0]    rack;
    logic [31:0]    rbits;
  } link_req_t;

  // One result as it should appear on the output channel.
  typedef struct packed {
    logic [15:0] tx_seq;
    logic [15:0] tx_ack;
    logic [31:0] tx_bits;
    logic        accepted;
    logic [31:0] avg_us;
    logic [31:0] jit_us;
    logic [31:0] min_us;
    logic [31:0] acked;
    logic [31:0] lost;
  } link_res_t;

  localparam int unsigned Depth      = 256;
  localparam int unsigned CycleLimit = 2000000;
  localparam int unsigned HoldCycles = 1500;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [7:0]  cfg_wdata_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  cmd_i;
  logic [31:0] now_us_i;
  logic [15:0] rx_sequence_i;
  logic [15:0] rx_ack_i;
  logic [31:0] rx_ack_bits_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [15:0] tx_sequence_o;
  logic [15:0] tx_ack_o;
  logic [31:0] tx_ack_bits_o;
  logic        rx_accepted_o;
  logic [31:0] rtt_avg_us_o;
  logic [31:0] rtt_jitter_us_o;
  logic [31:0] rtt_min_us_o;
  logic [31:0] acked_total_o;
  logic [31:0] lost_total_o;

  packet_ack_rtt_tracker_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .cmd_i          (cmd_i),
    .now_us_i       (now_us_i),
    .rx_sequence_i  (rx_sequence_i),
    .rx_ack_i       (rx_ack_i),
    .rx_ack_bits_i  (rx_ack_bits_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .tx_sequence_o  (tx_sequence_o),
    .tx_ack_o       (tx_ack_o),
    .tx_ack_bits_o  (tx_ack_bits_o),
    .rx_accepted_o  (rx_accepted_o),
    .rtt_avg_us_o   (rtt_avg_us_o),
    .rtt_jitter_us_o(rtt_jitter_us_o),
    .rtt_min_us_o   (rtt_min_us_o),
    .acked_total_o  (acked_total_o),
    .lost_total_o   (lost_total_o)
  );

  // Requests still to be offered, and results the tracker still owes us.
  link_req_t pending_reqs[$];
  link_res_t owed_results[$];

  int unsigned cycle_count;
  int unsigned failures;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  logic        hold_rx;

  // Shadow of the tracker's state, kept in step with every accepted request.
  logic [7:0]  horizon_cfg;
  logic [15:0] next_tx_seq;
  logic [15:0] tx_tag   [Depth];
  logic        tx_live  [Depth];
  logic        tx_acked [Depth];
  logic [31:0] tx_stamp [Depth];
  logic [15:0] rx_tag   [Depth];
  logic        rx_live  [Depth];
  logic [15:0] newest_rx;
  logic        seen_rx;
  logic [47:0] avg_fix;
  logic [47:0] jit_fix;
  logic [31:0] least_rtt;
  logic        rtt_seeded;
  logic [15:0] loss_cursor;
  logic        cursor_set;
  logic [31:0] acked_sum;
  logic [31:0] lost_sum;

  // Stimulus bookkeeping: how many sends have been queued, the partner's own
  // sequence counter and a free-running clock for the time stamps.
  logic [15:0] sends_queued;
  logic [15:0] partner_seq;
  logic [31:0] wall_us;

  function automatic logic ahead_of(logic [15:0] a, logic [15:0] b);
    logic [15:0] ab;
    logic [15:0] ba;
    ab = a - b;
    ba = b - a;
    return ((a > b) && (ab <= 16'h8000)) || ((a < b) && (ba > 16'h8000));
  endfunction

  // Moves x toward t by alpha of the distance, rounding the step half up.
  function automatic logic [47:0] smooth_toward(logic [47:0] x, logic [47:0] t);
    logic [63:0] span;
    logic [63:0] step;
    span = (t >= x) ? 64'(t - x) : 64'(x - t);
    step = (span * 64'd6554 + 64'd32768) >> 16;
    return (t >= x) ? 48'(x + step) : 48'(x - step);
  endfunction

  function automatic void take_ack(logic [15:0] seq, logic [31:0] now);
    int unsigned slot;
    logic [31:0] rtt;
    logic [47:0] rtt_fix;
    logic [47:0] gap;
    slot = seq % Depth;
    if (!tx_live[slot] || tx_tag[slot] != seq || tx_acked[slot]) return;
    tx_acked[slot] = 1'b1;
    acked_sum++;
    rtt = now - tx_stamp[slot];
    rtt_fix = {rtt, 16'h0};
    if (!rtt_seeded) begin
      avg_fix = rtt_fix;
      least_rtt = rtt;
      rtt_seeded = 1'b1;
      return;
    end
    gap = (rtt_fix >= avg_fix) ? rtt_fix - avg_fix : avg_fix - rtt_fix;
    jit_fix = smooth_toward(jit_fix, gap);
    avg_fix = smooth_toward(avg_fix, rtt_fix);
    if (rtt < least_rtt) least_rtt = rtt;
  endfunction

  function automatic link_res_t track_request(link_req_t r);
    link_res_t   res;
    int unsigned slot;
    logic [15:0] horizon;
    logic [15:0] probe;
    res = '0;
    case (r.cmd)
      part_pkg::CmdSend: begin
        res.tx_seq = next_tx_seq;
        if (seen_rx) begin
          res.tx_ack = newest_rx;
          for (int i = 0; i < 32; i++) begin
            probe = newest_rx - 16'(i + 1);
            if (rx_live[probe % Depth] && rx_tag[probe % Depth] == probe)
              res.tx_bits[i] = 1'b1;
          end
        end
        slot = next_tx_seq % Depth;
        tx_tag[slot] = next_tx_seq;
        tx_live[slot] = 1'b1;
        tx_acked[slot] = 1'b0;
        tx_stamp[slot] = r.now;
        next_tx_seq++;
      end
      part_pkg::CmdRecv: begin
        slot = r.rseq % Depth;
        if (!(rx_live[slot] && rx_tag[slot] == r.rseq)) begin
          res.accepted = 1'b1;
          rx_tag[slot] = r.rseq;
          rx_live[slot] = 1'b1;
          if (!seen_rx || ahead_of(r.rseq, newest_rx)) newest_rx = r.rseq;
          seen_rx = 1'b1;
          take_ack(r.rack, r.now);
          for (int i = 0; i < 32; i++)
            if (r.rbits[i]) take_ack(r.rack - 16'(i + 1), r.now);
        end
      end
      part_pkg::CmdTick: begin
        horizon = next_tx_seq - 16'(horizon_cfg);
        if (!cursor_set) begin
          loss_cursor = horizon;
          cursor_set = 1'b1;
        end
        while (ahead_of(horizon, loss_cursor)) begin
          slot = loss_cursor % Depth;
          if (tx_live[slot] && tx_tag[slot] == loss_cursor && !tx_acked[slot])
            lost_sum++;
          loss_cursor++;
        end
      end
      default: begin
      end
    endcase
    res.avg_us = avg_fix[47:16];
    res.jit_us = jit_fix[47:16];
    res.min_us = least_rtt;
    res.acked = acked_sum;
    res.lost = lost_sum;
    return res;
  endfunction

  // Clock generation.
  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Watchdog: a hung tracker must not keep the simulation running for ever.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // Request driver. The prediction is made at the edge that accepts a
  // request, so the shadow state advances in exactly the tracker's order.
  // A new request is only picked up once the current one has gone.
  always @(posedge clk_i) begin
    link_req_t nxt;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o)
        owed_results.insert(owed_results.size(),
                            track_request(link_req_t'{part_pkg::cmd_e'(cmd_i), now_us_i,
                                          rx_sequence_i, rx_ack_i, rx_ack_bits_i}));
      if (!in_valid_i || in_ready_o) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_reqs.pop_front();
          in_valid_i    <= 1'b1;
          cmd_i         <= nxt.cmd;
          now_us_i      <= nxt.now;
          rx_sequence_i <= nxt.rseq;
          rx_ack_i      <= nxt.rack;
          rx_ack_bits_i <= nxt.rbits;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor: every accepted result is checked against the oldest
  // owed one, field by field.
  always @(posedge clk_i) begin
    link_res_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (owed_results.size() == 0) begin
          $error("unexpected result, nothing outstanding");
          failures++;
        end else begin
          want = owed_results.pop_front();
          if (tx_sequence_o !== want.tx_seq) begin
            $error("tx_sequence expected %0h actual %0h", want.tx_seq, tx_sequence_o);
            failures++;
          end
          if (tx_ack_o !== want.tx_ack) begin
            $error("tx_ack expected %0h actual %0h", want.tx_ack, tx_ack_o);
            failures++;
          end
          if (tx_ack_bits_o !== want.tx_bits) begin
            $error("tx_ack_bits expected %0h actual %0h", want.tx_bits, tx_ack_bits_o);
            failures++;
          end
          if (rx_accepted_o !== want.accepted) begin
            $error("rx_accepted expected %0h actual %0h", want.accepted, rx_accepted_o);
            failures++;
          end
          if (rtt_avg_us_o !== want.avg_us) begin
            $error("rtt_avg_us expected %0h actual %0h", want.avg_us, rtt_avg_us_o);
            failures++;
          end
          if (rtt_jitter_us_o !== want.jit_us) begin
            $error("rtt_jitter_us expected %0h actual %0h", want.jit_us, rtt_jitter_us_o);
            failures++;
          end
          if (rtt_min_us_o !== want.min_us) begin
            $error("rtt_min_us expected %0h actual %0h", want.min_us, rtt_min_us_o);
            failures++;
          end
          if (acked_total_o !== want.acked) begin
            $error("acked_total expected %0h actual %0h", want.acked, acked_total_o);
            failures++;
          end
          if (lost_total_o !== want.lost) begin
            $error("lost_total expected %0h actual %0h", want.lost, lost_total_o);
            failures++;
          end
        end
      end
      out_ready_i <= !hold_rx && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic void queue_req(part_pkg::cmd_e cmd, logic [31:0] now,
                                    logic [15:0] rseq, logic [15:0] rack,
                                    logic [31:0] rbits);
    pending_reqs.insert(pending_reqs.size(), link_req_t'{cmd, now, rseq, rack, rbits});
    if (cmd == part_pkg::CmdSend) sends_queued++;
  endfunction

  // One random request. Most are well formed: sends, and receives whose
  // acks point at recently sent packets with a realistic round trip. The
  // rest are duplicates, stale acks and plain noise.
  function automatic void queue_random_req();
    int unsigned pick;
    logic [15:0] rseq;
    logic [15:0] rack;
    pick = $urandom_range(99);
    if ($urandom_range(49) == 0) wall_us += $urandom;
    else wall_us += $urandom_range(0, 3000);
    if (pick < 40) begin
      queue_req(part_pkg::CmdSend, wall_us, 16'($urandom), 16'($urandom), $urandom);
    end else if (pick < 80) begin
      case ($urandom_range(9))
        0: rseq = partner_seq - 16'($urandom_range(1, 40));
        1: rseq = 16'($urandom);
        default: begin
          rseq = partner_seq;
          partner_seq++;
        end
      endcase
      rack = sends_queued - 16'($urandom_range(1, 6));
      queue_req(part_pkg::CmdRecv, wall_us, rseq, rack, $urandom);
    end else if (pick < 92) begin
      queue_req(part_pkg::CmdTick, wall_us, 16'($urandom), 16'($urandom), $urandom);
    end else if (pick < 95) begin
      queue_req(part_pkg::CmdNop, wall_us, 16'($urandom), 16'($urandom), $urandom);
    end else begin
      queue_req(part_pkg::cmd_e'($urandom_range(3)), $urandom, 16'($urandom),
                16'($urandom), $urandom);
    end
  endfunction

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || in_valid_i || owed_results.size() > 0)
      @(posedge clk_i);
    // Settle time before any register write.
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_horizon(logic [7:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    horizon_cfg = value;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    logic [7:0] horizons [6];
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    in_valid_i    = 1'b0;
    cmd_i         = part_pkg::CmdNop;
    now_us_i      = '0;
    rx_sequence_i = '0;
    rx_ack_i      = '0;
    rx_ack_bits_i = '0;
    out_ready_i   = 1'b0;
    hold_rx       = 1'b0;
    cycle_count   = 0;
    failures      = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;

    horizon_cfg = part_pkg::LossHorizonReset;
    next_tx_seq = '0;
    for (int i = 0; i < Depth; i++) begin
      tx_live[i]  = 1'b0;
      tx_acked[i] = 1'b0;
      rx_live[i]  = 1'b0;
    end
    newest_rx   = '0;
    seen_rx     = 1'b0;
    avg_fix     = '0;
    jit_fix     = '0;
    least_rtt   = '0;
    rtt_seeded  = 1'b0;
    loss_cursor = '0;
    cursor_set  = 1'b0;
    acked_sum   = '0;
    lost_sum    = '0;
    sends_queued = '0;
    partner_seq  = 16'd5;
    wall_us      = 32'd1000;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed opening: a tick with nothing sent, extreme time stamps,
    // wrap-aware newest sequence, duplicates, repeated and unknown acks,
    // a full ack map and the unused command.
    queue_req(part_pkg::CmdTick, 32'h0, 16'h0, 16'h0, 32'h0);
    queue_req(part_pkg::CmdSend, 32'h0, 16'h0, 16'h0, 32'h0);
    queue_req(part_pkg::CmdSend, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    queue_req(part_pkg::CmdSend, 32'h10, 16'h0, 16'h0, 32'h0);
    queue_req(part_pkg::CmdRecv, 32'h64, 16'h0, 16'h0, 32'h0);
    queue_req(part_pkg::CmdRecv, 32'h70, 16'h0, 16'h2, 32'h1);
    queue_req(part_pkg::CmdRecv, 32'h200, 16'hFFFF, 16'h2, 32'hFFFF_FFFF);
    queue_req(part_pkg::CmdRecv, 32'h300, 16'h8000, 16'h1, 32'h0);
    queue_req(part_pkg::CmdSend, 32'h400, 16'h0, 16'h0, 32'h0);
    queue_req(part_pkg::CmdRecv, 32'h0, 16'h0001, 16'h3, 32'h0);
    queue_req(part_pkg::CmdRecv, 32'hFFFF_FF00, 16'h0002, 16'hFFFF, 32'hFFFF_FFFF);
    queue_req(part_pkg::CmdNop, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    queue_req(part_pkg::CmdTick, 32'h500, 16'h0, 16'h0, 32'h0);
    queue_req(part_pkg::CmdSend, 32'h600, 16'h0, 16'h0, 32'h0);
    wait_drained();

    // Phases of random traffic over several horizons, the extremes and an
    // out-of-range zero among them, each with one of four idling patterns.
    horizons = '{8'd32, 8'd1, 8'd255, 8'd0, 8'($urandom_range(2, 254)), 8'd8};
    for (int ph = 0; ph < 6; ph++) begin
      write_horizon(horizons[ph]);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
        default: begin send_idle_pct = 34; recv_stall_pct = 34; end
      endcase
      // Packets lost under a tight horizon and only acknowledged afterwards.
      if (ph == 1) begin
        for (int i = 0; i < 4; i++)
          queue_req(part_pkg::CmdSend, wall_us, 16'h0, 16'h0, 32'h0);
        queue_req(part_pkg::CmdTick, wall_us, 16'h0, 16'h0, 32'h0);
        queue_req(part_pkg::CmdRecv, wall_us + 32'd900, partner_seq, sends_queued - 16'd1,
                  32'h7);
        partner_seq++;
      end
      // A long receiver hold-off while requests keep coming.
      if (ph == 2) begin
        fork
          begin
            hold_rx <= 1'b1;
            repeat (HoldCycles) @(posedge clk_i);
            hold_rx <= 1'b0;
          end
        join_none
      end
      for (int i = 0; i < 115; i++) queue_random_req();
      wait_drained();
    end

    if (failures == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
